### sv/mfek_pkg.sv
// shared types and constants for the edmonds-karp max flow block
package mfek_pkg;

  localparam int NODES = 64;
  localparam int NODE_W = 6;
  localparam int ADDR_W = 12;
  localparam int RES_W = 32;
  localparam int FLOW_W = 32;
  localparam logic [RES_W-1:0] PATH_CAP = RES_W'(1000000);
  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_LOAD = 3'd1,
    CMD_INIT = 3'd2,
    CMD_BFS = 3'd3,
    CMD_AUG = 3'd4,
    CMD_CLEAR = 3'd5,
    CMD_BOOT = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic found;
  } sts_t;

endpackage

### sv/max_flow_edmonds_karp.sv
// top level of the edmonds-karp max flow block
// usage:
//   cfg_we with cfg_node_count sets node_count (sink node; source is node one),
//   to be written only while idle; the block does not enforce this.
//   start with in_func=0 loads capacity into entry (in_edge_from, in_edge_to),
//   saturating; self loops and nodes outside 1..64 are dropped. busy stays low,
//   so loads go one per cycle; the write-back lands the cycle after accept.
//   start with in_func=1 runs the flow search with busy high. when no path is
//   left the matrix is cleared, then out_strobe is high for one cycle with
//   out_max_flow and busy drops the cycle after.
// run sequence: each breadth-first search scans one matrix row per dequeued
//   node through the single matrix read port, each augmentation walks the
//   path edges twice, then all 4096 matrix entries are cleared and the
//   result is emitted.
// reset: a clearing pass over all 4096 matrix entries runs with busy high.
// the receiver cannot stall; out_strobe is a single-cycle pulse.
module max_flow_edmonds_karp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [6:0]  in_edge_from,
  input  logic [6:0]  in_edge_to,
  input  logic [15:0] in_capacity,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_node_count,
  output logic        out_strobe,
  output logic [31:0] out_max_flow
);

  logic [6:0]     node_count_r;
  mfek_pkg::ctl_t ctl;
  mfek_pkg::sts_t sts;
  logic           busy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= 7'd64;
    else if (cfg_we) node_count_r <= cfg_node_count;
  end

  mfek_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_func(in_func),
    .sts(sts), .ctl(ctl), .busy(busy_c), .out_strobe(out_strobe)
  );

  mfek_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .node_count(node_count_r),
    .edge_from(in_edge_from), .edge_to(in_edge_to), .capacity(in_capacity),
    .sts(sts), .max_flow(out_max_flow)
  );

  assign busy = busy_c;

endmodule

### sv/mfek_ctrl.sv
// controller state machine for the max flow block
module mfek_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_func,
  input  mfek_pkg::sts_t sts,
  output mfek_pkg::ctl_t ctl,
  output logic          busy,
  output logic          out_strobe
);

  typedef enum logic [5:0] {
    ST_BOOT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_BFS   = 6'b000100,
    ST_AUG   = 6'b001000,
    ST_CLEAR = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_BOOT;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl.cmd = mfek_pkg::CMD_NONE;
    case (state_r)
      ST_BOOT: begin
        ctl.cmd = mfek_pkg::CMD_BOOT;
        if (sts.done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (in_func) begin
            ctl.cmd = mfek_pkg::CMD_INIT;
            state_nxt = ST_BFS;
          end else begin
            ctl.cmd = mfek_pkg::CMD_LOAD;
          end
        end
      end
      ST_BFS: begin
        ctl.cmd = mfek_pkg::CMD_BFS;
        if (sts.done) state_nxt = sts.found ? ST_AUG : ST_CLEAR;
      end
      ST_AUG: begin
        ctl.cmd = mfek_pkg::CMD_AUG;
        if (sts.done) state_nxt = ST_BFS;
      end
      ST_CLEAR: begin
        ctl.cmd = mfek_pkg::CMD_CLEAR;
        if (sts.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_BOOT;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_EMIT);

endmodule

### sv/mfek_dp.sv
// datapath: residual matrix memory, bfs unit, path augmentation and flow total
module mfek_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mfek_pkg::ctl_t              ctl,
  input  logic [6:0]                  node_count,
  input  logic [6:0]                  edge_from,
  input  logic [6:0]                  edge_to,
  input  logic [15:0]                 capacity,
  output mfek_pkg::sts_t              sts,
  output logic [mfek_pkg::FLOW_W-1:0] max_flow
);

  localparam int NW = mfek_pkg::NODE_W;
  localparam int AW = mfek_pkg::ADDR_W;
  localparam int RW = mfek_pkg::RES_W;

  // phase encodings of the internal sub-sequencers
  typedef enum logic [3:0] {
    PH_RD   = 4'd0,
    PH_WT   = 4'd1,
    PH_USE  = 4'd2,
    PH_WR   = 4'd3,
    PH_POP  = 4'd4,
    PH_SCAN = 4'd5,
    PH_SWT  = 4'd6,
    PH_SUSE = 4'd7,
    PH_FIN  = 4'd8,
    PH_BRD  = 4'd9,
    PH_BWT  = 4'd10,
    PH_BUSE = 4'd11,
    PH_FWD  = 4'd12,
    PH_REV  = 4'd13,
    PH_REVW = 4'd14
  } phase_t;

  logic [RW-1:0] mem [mfek_pkg::NODES*mfek_pkg::NODES];
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [RW-1:0] wr_data, rd_data_r;

  // pending load: the read issued at accept returns next cycle and is written back
  logic          ld_pend_r;
  logic [AW-1:0] ld_addr_r;
  logic [15:0]   ld_cap_r;
  logic          byp_r;
  logic [RW-1:0] byp_data_r;
  logic [RW-1:0] ld_base;
  logic [RW:0]   ld_sum;
  logic [RW-1:0] ld_data;

  logic [RW-1:0] mem_wdata;
  logic [AW-1:0] mem_waddr;
  logic          mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  logic [NW-1:0] parent_mem [mfek_pkg::NODES];
  logic [NW-1:0] queue_mem [mfek_pkg::NODES];
  logic [mfek_pkg::NODES-1:0] visited_r, visited_nxt;

  phase_t        ph_r, ph_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [NW-1:0] u_r, u_nxt, i_r, i_nxt, cur_r, cur_nxt, par_r, par_nxt;
  logic [NW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [RW-1:0] f_r, f_nxt;
  logic [mfek_pkg::FLOW_W-1:0] flow_r, flow_nxt;
  logic [NW-1:0] last;
  logic [NW-1:0] ld_from, ld_to;
  logic          ld_ok;
  logic [RW:0]   sum;
  logic [mfek_pkg::FLOW_W:0] fsum;
  logic [NW-1:0] pq_rd, qu_rd;
  logic          pw_en, qw_en;
  logic [NW-1:0] pw_addr, pw_data, qw_addr, qw_data;
  logic [NW-1:0] pq_r, qu_r;

  always_comb begin
    if (node_count == 7'd0) last = '0;
    else if (node_count > 7'(mfek_pkg::NODES)) last = NW'(mfek_pkg::NODES - 1);
    else last = NW'(node_count - 7'd1);
  end

  assign ld_from = NW'(edge_from - 7'd1);
  assign ld_to = NW'(edge_to - 7'd1);
  assign ld_ok = (edge_from != edge_to) && (edge_from != 7'd0) && (edge_to != 7'd0)
                 && (edge_from <= 7'(mfek_pkg::NODES)) && (edge_to <= 7'(mfek_pkg::NODES));

  always_ff @(posedge clk) begin
    if (pw_en) parent_mem[pw_addr] <= pw_data;
    if (qw_en) queue_mem[qw_addr] <= qw_data;
    pq_r <= parent_mem[pq_rd];
    qu_r <= queue_mem[qu_rd];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_RD;
      sweep_r <= '0;
      flow_r <= '0;
      visited_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      sweep_r <= sweep_nxt;
      flow_r <= flow_nxt;
      visited_r <= visited_nxt;
    end
    u_r <= u_nxt; i_r <= i_nxt; cur_r <= cur_nxt; par_r <= par_nxt;
    head_r <= head_nxt; tail_r <= tail_nxt; f_r <= f_nxt;
  end

  always_comb begin
    ph_nxt = ph_r; sweep_nxt = sweep_r; flow_nxt = flow_r; visited_nxt = visited_r;
    u_nxt = u_r; i_nxt = i_r; cur_nxt = cur_r; par_nxt = par_r;
    head_nxt = head_r; tail_nxt = tail_r; f_nxt = f_r;
    rd_addr = {ld_from, ld_to};
    wr_addr = {ld_from, ld_to}; wr_en = 1'b0; wr_data = '0;
    pw_en = 1'b0; pw_addr = '0; pw_data = '0; pq_rd = cur_r;
    qw_en = 1'b0; qw_addr = '0; qw_data = '0; qu_rd = head_r[NW-1:0];
    sum = '0; fsum = '0;
    sts.done = 1'b0; sts.found = 1'b0;
    case (ctl.cmd)
      mfek_pkg::CMD_BOOT, mfek_pkg::CMD_CLEAR: begin
        // one matrix entry a cycle
        wr_en = 1'b1; wr_addr = sweep_r; wr_data = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) sts.done = 1'b1;
      end
      mfek_pkg::CMD_LOAD: begin
        // matrix read goes out at accept, the write-back lands the next cycle
        ph_nxt = PH_RD;
      end
      mfek_pkg::CMD_INIT: begin
        flow_nxt = '0;
        ph_nxt = PH_FIN;
      end
      mfek_pkg::CMD_BFS: begin
        case (ph_r)
          PH_FIN: begin
            visited_nxt = '0; visited_nxt[0] = 1'b1;
            qw_en = 1'b1; qw_addr = '0; qw_data = '0;
            head_nxt = '0; tail_nxt = (NW+1)'(1);
            ph_nxt = PH_POP;
            if (last == '0) begin
              sts.done = 1'b1; ph_nxt = PH_FIN;
            end
          end
          PH_POP: begin
            if (head_r == tail_r) begin
              sts.done = 1'b1; ph_nxt = PH_FIN;
            end else begin
              qu_rd = head_r[NW-1:0];
              head_nxt = head_r + 1'b1;
              ph_nxt = PH_WT;
            end
          end
          PH_WT: begin
            u_nxt = qu_r;
            i_nxt = '0;
            if (qu_r == last) begin
              sts.done = 1'b1; sts.found = 1'b1; ph_nxt = PH_BRD;
              cur_nxt = last; f_nxt = mfek_pkg::PATH_CAP;
            end else ph_nxt = PH_SCAN;
          end
          PH_SCAN: begin
            rd_addr = {u_r, i_r};
            ph_nxt = PH_SUSE;
          end
          PH_SUSE: begin
            if (!visited_r[i_r] && rd_data_r != '0) begin
              visited_nxt[i_r] = 1'b1;
              pw_en = 1'b1; pw_addr = i_r; pw_data = u_r;
              qw_en = 1'b1; qw_addr = tail_r[NW-1:0]; qw_data = i_r;
              tail_nxt = tail_r + 1'b1;
            end
            if (i_r == last) ph_nxt = PH_POP;
            else begin
              i_nxt = i_r + 1'b1; ph_nxt = PH_SCAN;
            end
          end
          default: ph_nxt = PH_FIN;
        endcase
      end
      mfek_pkg::CMD_AUG: begin
        case (ph_r)
          PH_BRD: begin
            pq_rd = cur_r; ph_nxt = PH_BWT;
          end
          PH_BWT: begin
            par_nxt = pq_r; ph_nxt = PH_BUSE;
          end
          PH_BUSE: begin
            rd_addr = {par_r, cur_r}; ph_nxt = PH_USE;
          end
          PH_USE: begin
            if (rd_data_r < f_r) f_nxt = rd_data_r;
            cur_nxt = par_r;
            if (par_r == '0) begin
              cur_nxt = last; ph_nxt = PH_RD;
            end else ph_nxt = PH_BRD;
          end
          PH_RD: begin
            pq_rd = cur_r; ph_nxt = PH_WT;
          end
          PH_WT: begin
            par_nxt = pq_r; ph_nxt = PH_FWD;
          end
          PH_FWD: begin
            rd_addr = {par_r, cur_r}; ph_nxt = PH_REV;
          end
          PH_REV: begin
            wr_en = 1'b1; wr_addr = {par_r, cur_r}; wr_data = rd_data_r - f_r;
            rd_addr = {cur_r, par_r}; ph_nxt = PH_REVW;
          end
          PH_REVW: begin
            sum = {1'b0, rd_data_r} + {1'b0, f_r};
            wr_en = 1'b1; wr_addr = {cur_r, par_r};
            wr_data = sum[RW] ? mfek_pkg::RES_MAX : sum[RW-1:0];
            cur_nxt = par_r;
            if (par_r == '0) begin
              fsum = {1'b0, flow_r} + {1'b0, f_r};
              flow_nxt = fsum[mfek_pkg::FLOW_W] ? mfek_pkg::FLOW_MAX
                                                : fsum[mfek_pkg::FLOW_W-1:0];
              sts.done = 1'b1; ph_nxt = PH_FIN;
            end else ph_nxt = PH_RD;
          end
          default: ph_nxt = PH_RD;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_pend_r <= 1'b0;
      byp_r <= 1'b0;
    end else begin
      ld_pend_r <= (ctl.cmd == mfek_pkg::CMD_LOAD) && ld_ok;
      // back-to-back loads to one entry: the read saw the old value, forward the new one
      byp_r <= (ctl.cmd == mfek_pkg::CMD_LOAD) && ld_pend_r
               && (ld_addr_r == {ld_from, ld_to});
    end
    ld_addr_r <= {ld_from, ld_to};
    ld_cap_r <= capacity;
    byp_data_r <= ld_data;
  end

  assign ld_base = byp_r ? byp_data_r : rd_data_r;
  assign ld_sum = {1'b0, ld_base} + {{(RW-15){1'b0}}, ld_cap_r};
  assign ld_data = ld_sum[RW] ? mfek_pkg::RES_MAX : ld_sum[RW-1:0];

  // final write port mux (load write-back only happens right after a load accept)
  assign mem_we = wr_en || ld_pend_r;
  assign mem_waddr = ld_pend_r ? ld_addr_r : wr_addr;
  assign mem_wdata = ld_pend_r ? ld_data : wr_data;

  assign max_flow = flow_r;

endmodule
